// ===== rtl/core/zmtm_pkg.sv =====
// zmtm_pkg: shared constants for the table memory unit
package zmtm_pkg;

    // default depth of the byte memory, as address bits
    localparam int ADDR_BITS_DEFAULT = 16;

    // instruction codes
    localparam logic [2:0] MODE_COPY    = 3'd0;
    localparam logic [2:0] MODE_SCAN    = 3'd1;
    localparam logic [2:0] MODE_LOAD_B  = 3'd2;
    localparam logic [2:0] MODE_LOAD_W  = 3'd3;
    localparam logic [2:0] MODE_STORE_B = 3'd4;
    localparam logic [2:0] MODE_STORE_W = 3'd5;

    // scan form fields
    localparam logic [7:0] SCAN_DEFAULT_FORM = 8'h82;
    localparam logic [7:0] FORM_WORD_BIT     = 8'h80;
    localparam logic [7:0] FORM_STRIDE_MASK  = 8'h7f;
    localparam logic [2:0] FULL_OPERAND_COUNT = 3'd4;

endpackage

// ===== rtl/core/zmtm_ram.sv =====
// zmtm_ram: byte memory with one write port and one registered read port
module zmtm_ram #(
    parameter int ADDR_BITS = zmtm_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [7:0]           i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [7:0]           o_rdata
);

    logic [7:0] r_mem [2**ADDR_BITS];
    logic [7:0] r_rdata;

    // write port and registered read, read returns old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/zmachine_table_memory_unit_core.sv =====
// zmachine_table_memory_unit_core: sequencer for byte, word and table instructions
// Loads pass S_LD_RD, S_LD_HI (and S_LD_LO for words) and S_OUT on the way to the output word;
// stores pass S_ST1 (and S_ST2 for words) and S_OUT; the next word is taken in the cycle the result appears.
// Copy reads then writes each byte, zero fill writes each byte in S_FILL, and scan checks the count, then
// reads one (byte) or two (word) bytes per entry; the one read port of the byte memory sets the pace.
// One instruction in flight; a new one is taken while a result waits in the output register.
// Reset (synchronous, active low) clears the sequencer and the output valid, not the memory.
module zmachine_table_memory_unit_core #(
    parameter int ADDR_BITS = zmtm_pkg::ADDR_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic [15:0] i_operand_c,
    input  logic [7:0]  i_operand_d,
    input  logic [2:0]  i_operand_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_result_word,
    output logic        o_stores_result,
    output logic        o_branch_condition
);

    typedef enum logic [3:0] {
        S_IDLE, S_LD_RD, S_LD_HI, S_LD_LO, S_ST1, S_ST2, S_FILL,
        S_CP_RD, S_CP_WR, S_SC_CHK, S_SC_B0, S_SC_B1, S_OUT
    } t_state;

    t_state      r_state;
    logic [2:0]  r_mode;
    logic [15:0] r_src;
    logic [15:0] r_dst;
    logic [15:0] r_count;
    logic [15:0] r_value;
    logic [15:0] r_res;
    logic        r_word;
    logic        r_up;
    logic [6:0]  r_stride;
    logic [7:0]  r_hi;
    logic        r_out_valid;
    logic [15:0] r_result;
    logic        r_stores;
    logic        r_branch;

    logic [15:0] w_src_step;
    logic [15:0] w_src_next;
    logic [15:0] w_src_inc;
    logic [15:0] w_dst_next;
    logic [15:0] w_entry;
    logic        w_match;
    logic        w_mem_we;
    logic [15:0] w_mem_waddr;
    logic [7:0]  w_mem_wdata;
    logic [15:0] w_mem_raddr;
    logic [7:0]  w_mem_rdata;
    logic        w_default_form;
    logic [7:0]  w_form;
    logic        w_out_load;

    // byte memory
    zmtm_ram #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr[ADDR_BITS-1:0]),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr[ADDR_BITS-1:0]),
        .o_rdata (w_mem_rdata)
    );

    // pointer stepping: stride while scanning, +1 or -1 while copying
    always_comb begin
        if (r_state == S_SC_B0 || r_state == S_SC_B1) begin
            w_src_step = {9'd0, r_stride};
        end else if (r_up) begin
            w_src_step = 16'h0001;
        end else begin
            w_src_step = 16'hffff;
        end
    end

    assign w_src_next = r_src + w_src_step;
    assign w_src_inc  = r_src + 16'h0001;
    assign w_dst_next = r_up ? (r_dst + 16'h0001) : (r_dst - 16'h0001);

    // scan entry compare
    assign w_entry = (r_state == S_SC_B1) ? {r_hi, w_mem_rdata} : {8'h00, w_mem_rdata};
    assign w_match = (w_entry == r_value);

    // scan form select
    assign w_default_form = (i_operand_count < zmtm_pkg::FULL_OPERAND_COUNT);
    assign w_form = w_default_form ? zmtm_pkg::SCAN_DEFAULT_FORM : i_operand_d;

    // result moves to the output register when it is free or being taken
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // memory port control
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_dst;
        w_mem_wdata = 8'h00;
        w_mem_raddr = r_src;
        unique case (r_state)
            S_LD_HI, S_SC_B0: begin
                w_mem_raddr = w_src_inc;
            end
            S_ST1: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = r_word ? r_value[15:8] : r_value[7:0];
            end
            S_ST2: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = r_value[7:0];
            end
            S_FILL: begin
                w_mem_we = (r_count != 16'd0);
            end
            S_CP_WR: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = w_mem_rdata;
            end
            default: begin
                w_mem_raddr = r_src;
            end
        endcase
    end

    // sequencer and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_up        <= 1'b1;
        end else begin
            r_out_valid <= w_out_load || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode <= i_mode;
                        r_res  <= 16'd0;
                        priority case (i_mode)
                            zmtm_pkg::MODE_COPY: begin
                                if (i_operand_b == 16'd0) begin
                                    r_dst   <= i_operand_a;
                                    r_count <= i_operand_c;
                                    r_up    <= 1'b1;
                                    r_state <= S_FILL;
                                end else if (i_operand_c[15] || i_operand_a > i_operand_b) begin
                                    r_src   <= i_operand_a;
                                    r_dst   <= i_operand_b;
                                    r_count <= i_operand_c[15] ? (16'd0 - i_operand_c)
                                                               : i_operand_c;
                                    r_up    <= 1'b1;
                                    r_state <= S_CP_RD;
                                end else begin
                                    r_src   <= i_operand_a + i_operand_c - 16'd1;
                                    r_dst   <= i_operand_b + i_operand_c - 16'd1;
                                    r_count <= i_operand_c;
                                    r_up    <= 1'b0;
                                    r_state <= S_CP_RD;
                                end
                            end
                            zmtm_pkg::MODE_SCAN: begin
                                r_src    <= i_operand_b;
                                r_value  <= i_operand_a;
                                r_count  <= i_operand_c;
                                r_word   <= (w_form & zmtm_pkg::FORM_WORD_BIT) != 8'h00;
                                r_stride <= w_form[6:0] & zmtm_pkg::FORM_STRIDE_MASK[6:0];
                                r_state  <= S_SC_CHK;
                            end
                            zmtm_pkg::MODE_LOAD_B: begin
                                r_src   <= i_operand_a + i_operand_b;
                                r_word  <= 1'b0;
                                r_state <= S_LD_RD;
                            end
                            zmtm_pkg::MODE_LOAD_W: begin
                                r_src   <= i_operand_a + {i_operand_b[14:0], 1'b0};
                                r_word  <= 1'b1;
                                r_state <= S_LD_RD;
                            end
                            zmtm_pkg::MODE_STORE_B: begin
                                r_dst   <= i_operand_a + i_operand_b;
                                r_value <= i_operand_c;
                                r_word  <= 1'b0;
                                r_up    <= 1'b1;
                                r_state <= S_ST1;
                            end
                            zmtm_pkg::MODE_STORE_W: begin
                                r_dst   <= i_operand_a + {i_operand_b[14:0], 1'b0};
                                r_value <= i_operand_c;
                                r_word  <= 1'b1;
                                r_up    <= 1'b1;
                                r_state <= S_ST1;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                // loads: first byte read issued here
                S_LD_RD: begin
                    r_state <= S_LD_HI;
                end
                S_LD_HI: begin
                    if (r_word) begin
                        r_hi    <= w_mem_rdata;
                        r_state <= S_LD_LO;
                    end else begin
                        r_res   <= {8'h00, w_mem_rdata};
                        r_state <= S_OUT;
                    end
                end
                S_LD_LO: begin
                    r_res   <= {r_hi, w_mem_rdata};
                    r_state <= S_OUT;
                end
                // stores: high byte first for words
                S_ST1: begin
                    r_dst   <= w_dst_next;
                    r_state <= r_word ? S_ST2 : S_OUT;
                end
                S_ST2: begin
                    r_state <= S_OUT;
                end
                // zero fill, one byte a cycle
                S_FILL: begin
                    if (r_count == 16'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_dst   <= w_dst_next;
                        r_count <= r_count - 16'd1;
                    end
                end
                // copy: read then write each byte
                S_CP_RD: begin
                    r_state <= (r_count == 16'd0) ? S_OUT : S_CP_WR;
                end
                S_CP_WR: begin
                    r_src   <= w_src_next;
                    r_dst   <= w_dst_next;
                    r_count <= r_count - 16'd1;
                    r_state <= S_CP_RD;
                end
                // scan: read entry, compare, step by stride
                S_SC_CHK: begin
                    r_state <= (r_count == 16'd0) ? S_OUT : S_SC_B0;
                end
                S_SC_B0: begin
                    if (r_word) begin
                        r_hi    <= w_mem_rdata;
                        r_state <= S_SC_B1;
                    end else if (w_match) begin
                        r_res   <= r_src;
                        r_state <= S_OUT;
                    end else begin
                        r_src   <= w_src_next;
                        r_count <= r_count - 16'd1;
                        r_state <= S_SC_CHK;
                    end
                end
                S_SC_B1: begin
                    if (w_match) begin
                        r_res   <= r_src;
                        r_state <= S_OUT;
                    end else begin
                        r_src   <= w_src_next;
                        r_count <= r_count - 16'd1;
                        r_state <= S_SC_CHK;
                    end
                end
                // hand the result to the output register once it is free
                S_OUT: begin
                    if (w_out_load) begin
                        r_result    <= r_res;
                        r_stores    <= (r_mode == zmtm_pkg::MODE_SCAN)
                                    || (r_mode == zmtm_pkg::MODE_LOAD_B)
                                    || (r_mode == zmtm_pkg::MODE_LOAD_W);
                        r_branch    <= (r_mode == zmtm_pkg::MODE_SCAN) && (r_res != 16'd0);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_result_word      = r_result;
    assign o_stores_result    = r_stores;
    assign o_branch_condition = r_branch;

endmodule

// ===== tb/sv/zmachine_table_memory_unit_core_tb.sv =====
// testbench for the table memory unit: directed and random instructions against a scoreboard
module zmachine_table_memory_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT    = 1000000;
    localparam int unsigned RANDOM_ITEMS   = 1300;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_MARGIN   = 12;

    typedef struct packed {
        bit [2:0]  mode;
        bit [15:0] op_a;
        bit [15:0] op_b;
        bit [15:0] op_c;
        bit [7:0]  op_d;
        bit [2:0]  op_count;
    } t_instr;

    typedef struct packed {
        bit [15:0] word;
        bit        stores;
        bit        branch;
    } t_result;

    // byte memory image plus the queue of results still owed by the block
    class t_story_scoreboard;
        bit [7:0]    mem [65536];
        t_result     pending_results [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned scan_hits;
        int unsigned per_mode [8];

        function bit [7:0] rd8(bit [15:0] addr);
            return mem[addr];
        endfunction

        // big-endian, second byte wraps past the top
        function bit [15:0] rd16(bit [15:0] addr);
            bit [15:0] nxt;
            nxt = addr + 16'd1;
            return {mem[addr], mem[nxt]};
        endfunction

        function void wr16(bit [15:0] addr, bit [15:0] v);
            bit [15:0] nxt;
            nxt = addr + 16'd1;
            mem[addr] = v[15:8];
            mem[nxt]  = v[7:0];
        endfunction

        // zero fill, forward copy or backward copy, byte by byte
        function void copy_table(bit [15:0] src, bit [15:0] dst, bit [15:0] len);
            int unsigned n;
            bit [15:0]   rd_at;
            bit [15:0]   wr_at;
            if (dst == 16'h0000) begin
                for (int unsigned i = 0; i < len; i++) begin
                    wr_at = src + i[15:0];
                    mem[wr_at] = 8'h00;
                end
            end else if (len[15] || src > dst) begin
                n = len[15] ? 32'h10000 - {16'h0000, len} : {16'h0000, len};
                for (int unsigned i = 0; i < n; i++) begin
                    rd_at = src + i[15:0];
                    wr_at = dst + i[15:0];
                    mem[wr_at] = mem[rd_at];
                end
            end else begin
                for (int unsigned i = {16'h0000, len}; i > 0; i--) begin
                    rd_at = src + i[15:0] - 16'd1;
                    wr_at = dst + i[15:0] - 16'd1;
                    mem[wr_at] = mem[rd_at];
                end
            end
        endfunction

        // walk entries until a match; address 0 reads the same as no match
        function bit [15:0] scan_table(bit [15:0] value, bit [15:0] addr, bit [15:0] count,
                                       bit [7:0] form);
            bit [15:0] entry;
            bit [7:0]  stride;
            stride = form & zmtm_pkg::FORM_STRIDE_MASK;
            for (int unsigned i = 0; i < count; i++) begin
                entry = ((form & zmtm_pkg::FORM_WORD_BIT) != 8'h00) ? rd16(addr)
                                                                    : {8'h00, rd8(addr)};
                if (entry == value) return addr;
                addr = addr + {8'h00, stride};
            end
            return 16'h0000;
        endfunction

        function t_result execute_instruction(t_instr ins);
            t_result   r;
            bit [7:0]  form;
            bit [15:0] addr;
            r = '0;
            case (ins.mode)
                zmtm_pkg::MODE_COPY: copy_table(ins.op_a, ins.op_b, ins.op_c);
                zmtm_pkg::MODE_SCAN: begin
                    form = (ins.op_count < zmtm_pkg::FULL_OPERAND_COUNT)
                         ? zmtm_pkg::SCAN_DEFAULT_FORM : ins.op_d;
                    r.word   = scan_table(ins.op_a, ins.op_b, ins.op_c, form);
                    r.stores = 1'b1;
                    r.branch = (r.word != 16'h0000);
                    if (r.branch) scan_hits++;
                end
                zmtm_pkg::MODE_LOAD_B: begin
                    addr     = ins.op_a + ins.op_b;
                    r.word   = {8'h00, rd8(addr)};
                    r.stores = 1'b1;
                end
                zmtm_pkg::MODE_LOAD_W: begin
                    addr     = ins.op_a + {ins.op_b[14:0], 1'b0};
                    r.word   = rd16(addr);
                    r.stores = 1'b1;
                end
                zmtm_pkg::MODE_STORE_B: begin
                    addr      = ins.op_a + ins.op_b;
                    mem[addr] = ins.op_c[7:0];
                end
                zmtm_pkg::MODE_STORE_W: begin
                    addr = ins.op_a + {ins.op_b[14:0], 1'b0};
                    wr16(addr, ins.op_c);
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_instruction(t_instr ins);
            per_mode[ins.mode]++;
            pending_results.push_back(execute_instruction(ins));
        endfunction

        function void compare_field(string name, bit [15:0] want, bit [15:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending, actual %h %b %b",
                         $time, got.word, got.stores, got.branch);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("result_word", want.word, got.word);
            compare_field("stores_result", {15'h0000, want.stores}, {15'h0000, got.stores});
            compare_field("branch_condition", {15'h0000, want.branch}, {15'h0000, got.branch});
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_mode = 3'd0;
    logic [15:0] i_operand_a = 16'h0000;
    logic [15:0] i_operand_b = 16'h0000;
    logic [15:0] i_operand_c = 16'h0000;
    logic [7:0]  i_operand_d = 8'h00;
    logic [2:0]  i_operand_count = 3'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_result_word;
    logic        o_stores_result;
    logic        o_branch_condition;

    t_story_scoreboard sb = new;

    bit          quiet_both = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned burst_left = 0;

    zmachine_table_memory_unit_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_operand_a        (i_operand_a),
        .i_operand_b        (i_operand_b),
        .i_operand_c        (i_operand_c),
        .i_operand_d        (i_operand_d),
        .i_operand_count    (i_operand_count),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_word      (o_result_word),
        .o_stores_result    (o_stores_result),
        .o_branch_condition (o_branch_condition)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output monitor
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.word   = o_result_word;
            got.stores = o_stores_result;
            got.branch = o_branch_condition;
            sb.check_result(got);
        end
    end

    // receiver: ready runs broken by short stalls, long hold-off on request
    initial begin : result_receiver
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (quiet_both) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin : stall_watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word accepted for %0d cycles", $time, quiet);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one instruction word, with burst gaps ahead of it
    task automatic send_instruction(t_instr ins);
        if (!quiet_both) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        i_in_valid      <= 1'b1;
        i_mode          <= ins.mode;
        i_operand_a     <= ins.op_a;
        i_operand_b     <= ins.op_b;
        i_operand_c     <= ins.op_c;
        i_operand_d     <= ins.op_d;
        i_operand_count <= ins.op_count;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_instruction(ins);
    endtask

    task automatic issue_instruction(bit [2:0] mode, bit [15:0] a, bit [15:0] b,
                                     bit [15:0] c, bit [7:0] d, bit [2:0] count);
        t_instr ins;
        ins = {mode, a, b, c, d, count};
        send_instruction(ins);
    endtask

    // stop offering until every owed result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_MARGIN) @(posedge i_clk);
    endtask

    // mostly two hot windows, one of them across the top of memory
    function automatic bit [15:0] pick_addr();
        bit [15:0] t;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: t = 16'(16'hFFC0 + $urandom_range(0, 127));
            4, 5, 6:    t = 16'(16'h7FC0 + $urandom_range(0, 127));
            default:    t = 16'($urandom);
        endcase
        return t;
    endfunction

    function automatic t_instr random_instruction();
        t_instr    ins;
        bit [15:0] target;
        bit [15:0] diff;
        bit [7:0]  form;
        int unsigned pick;
        int unsigned span;
        int        delta;
        ins.op_a     = 16'($urandom);
        ins.op_b     = 16'($urandom);
        ins.op_c     = 16'($urandom);
        ins.op_d     = 8'($urandom);
        ins.op_count = 3'($urandom_range(0, 4));
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            // loads and stores: random base, index chosen to land on a target
            target = pick_addr();
            diff   = target - ins.op_a;
            if (pick < 14)      ins.mode = zmtm_pkg::MODE_STORE_B;
            else if (pick < 30) ins.mode = zmtm_pkg::MODE_STORE_W;
            else if (pick < 44) ins.mode = zmtm_pkg::MODE_LOAD_B;
            else                ins.mode = zmtm_pkg::MODE_LOAD_W;
            if (ins.mode == zmtm_pkg::MODE_STORE_B || ins.mode == zmtm_pkg::MODE_LOAD_B)
                ins.op_b = diff;
            else
                ins.op_b = {ins.op_b[15], diff[15:1]};
        end else if (pick < 80) begin
            // scan, usually for a value known to sit in the table
            ins.mode = zmtm_pkg::MODE_SCAN;
            ins.op_b = pick_addr();
            ins.op_c = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(41, 600))
                                                     : 16'($urandom_range(0, 40));
            form = (ins.op_count < zmtm_pkg::FULL_OPERAND_COUNT) ? zmtm_pkg::SCAN_DEFAULT_FORM
                                                                 : ins.op_d;
            if (ins.op_c != 16'h0000 && $urandom_range(0, 9) < 6) begin
                target = 16'(ins.op_b + $urandom_range(0, ins.op_c - 1)
                                      * (form & zmtm_pkg::FORM_STRIDE_MASK));
                ins.op_a = ((form & zmtm_pkg::FORM_WORD_BIT) != 8'h00) ? sb.rd16(target)
                                                                       : {8'h00, sb.rd8(target)};
            end else if ((form & zmtm_pkg::FORM_WORD_BIT) == 8'h00
                         && $urandom_range(0, 1) == 1) begin
                ins.op_a[15:8] = 8'h00;
            end
        end else begin
            // copy: zero fill, negative size, or plain copy near the source
            ins.mode = zmtm_pkg::MODE_COPY;
            ins.op_a = pick_addr();
            span  = ($urandom_range(0, 39) == 0) ? $urandom_range(65, 2048) : $urandom_range(0, 64);
            delta = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 160)) - 80;
            ins.op_b = 16'(ins.op_a + delta);
            case ($urandom_range(0, 9))
                0, 1: begin
                    ins.op_b = 16'h0000;
                    ins.op_c = 16'(span);
                end
                2, 3, 4: ins.op_c = 16'(16'h0000 - span);
                default: ins.op_c = 16'(span);
            endcase
        end
        return ins;
    endfunction

    task automatic run_directed();
        // zero fill of everything but address 0, then a byte store to address 0 via wrapped index
        issue_instruction(zmtm_pkg::MODE_COPY,    16'h0001, 16'h0000, 16'hFFFF, 8'h00, 3'd3);
        issue_instruction(zmtm_pkg::MODE_STORE_B, 16'hFFFF, 16'h0001, 16'hFFA5, 8'hFF, 3'd4);
        // word straddling the top of memory
        issue_instruction(zmtm_pkg::MODE_STORE_W, 16'hFFFF, 16'h0000, 16'hBEEF, 8'h00, 3'd0);
        issue_instruction(zmtm_pkg::MODE_LOAD_W,  16'h0001, 16'h7FFF, 16'h0000, 8'h00, 3'd1);
        issue_instruction(zmtm_pkg::MODE_LOAD_B,  16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 3'd2);
        // small table at 0x1000: 12 34 ff ff 80
        issue_instruction(zmtm_pkg::MODE_STORE_W, 16'h1000, 16'h0000, 16'h1234, 8'h00, 3'd4);
        issue_instruction(zmtm_pkg::MODE_STORE_W, 16'h1000, 16'h0001, 16'hFFFF, 8'h00, 3'd4);
        issue_instruction(zmtm_pkg::MODE_STORE_B, 16'h1004, 16'h0000, 16'h0080, 8'h00, 3'd4);
        issue_instruction(zmtm_pkg::MODE_LOAD_B,  16'h1001, 16'hFFFF, 16'h0000, 8'h00, 3'd0);
        // default form, explicit byte form, miss, hit at address zero
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'hFFFF, 16'h1000, 16'h0003, 8'h01, 3'd2);
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'h0080, 16'h1000, 16'h0005, 8'h01, 3'd4);
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'h0077, 16'h1000, 16'h0005, 8'h01, 3'd4);
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'h00EF, 16'h0000, 16'h0002, 8'h01, 3'd4);
        // zero stride, zero count, full count with widest word stride, wrap
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'h1234, 16'h1000, 16'h0004, 8'h80, 3'd4);
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'hABCD, 16'h1000, 16'h0004, 8'h00, 3'd4);
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'h1234, 16'h1000, 16'h0000, 8'h82, 3'd4);
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'h0000, 16'h1000, 16'hFFFF, 8'hFF, 3'd4);
        issue_instruction(zmtm_pkg::MODE_SCAN,    16'hBEEF, 16'hFFFD, 16'h0003, 8'h00, 3'd0);
        // overlapping copies in every direction
        issue_instruction(zmtm_pkg::MODE_COPY,    16'h1000, 16'h0FFE, 16'h0005, 8'h00, 3'd0);
        issue_instruction(zmtm_pkg::MODE_COPY,    16'h0FFE, 16'h1000, 16'h0005, 8'h00, 3'd1);
        issue_instruction(zmtm_pkg::MODE_COPY,    16'h1000, 16'h1001, 16'hFFFC, 8'h00, 3'd2);
        issue_instruction(zmtm_pkg::MODE_COPY,    16'h1000, 16'h1000, 16'h0007, 8'h00, 3'd3);
        issue_instruction(zmtm_pkg::MODE_COPY,    16'h2000, 16'h1000, 16'h0000, 8'h00, 3'd4);
        issue_instruction(zmtm_pkg::MODE_COPY,    16'hFFF8, 16'h0010, 16'h0010, 8'h00, 3'd4);
        // most negative size, then read back from the copied half
        issue_instruction(zmtm_pkg::MODE_COPY,    16'h0000, 16'h8000, 16'h8000, 8'h00, 3'd4);
        issue_instruction(zmtm_pkg::MODE_LOAD_W,  16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, 3'd4);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200 || n == 700 || n == 1100) hold_off_req = 1'b1;
            if (n == 450 || n == 950) drain_results();
            quiet_both = (n >= 500 && n < 600) || (n >= 1000 && n < 1060);
            send_instruction(random_instruction());
        end
        quiet_both = 1'b0;
        drain_results();

        $display("ran %0d copies, %0d scans (%0d hits), %0d loads, %0d stores",
                 sb.per_mode[zmtm_pkg::MODE_COPY], sb.per_mode[zmtm_pkg::MODE_SCAN],
                 sb.scan_hits,
                 sb.per_mode[zmtm_pkg::MODE_LOAD_B] + sb.per_mode[zmtm_pkg::MODE_LOAD_W],
                 sb.per_mode[zmtm_pkg::MODE_STORE_B] + sb.per_mode[zmtm_pkg::MODE_STORE_W]);
        $display("%0d results checked with sender bursts, receiver stalls, long hold-offs and drains",
                 sb.checked);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/zmtm_pkg.sv
rtl/core/zmtm_ram.sv
rtl/core/zmachine_table_memory_unit_core.sv
tb/sv/zmachine_table_memory_unit_core_tb.sv
